// ===== hw/rtl/iaal_pkg.sv =====
package iaal_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FILT_W   = 32;
  localparam int unsigned MAP_W    = 9;
  localparam int unsigned CFG_IDX_W = 3;

  // register index codes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFFSET_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFFSET_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFFSET_Z = 3'd6;

  localparam logic [MAP_W-1:0] AXIS_MAP_RESET = 9'd354;

  // map field: bits 1:0 source axis, bit 2 negate
  localparam logic [1:0] SRC_ZERO = 2'd3;

  // Q1.30 filter coefficients
  localparam logic signed [31:0] COEF_A1 = 32'sd2071735500;
  localparam logic signed [31:0] COEF_A2 = -32'sd1000494913;
  localparam int unsigned        COEF_B_W = 23;
  localparam logic signed [COEF_B_W-1:0] COEF_B = 23'sd2501237;

  localparam int unsigned ACC_W = 66;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 66'sd536870912;
  localparam int unsigned Q_SHIFT = 30;

  typedef struct packed {
    logic load;    // capture products for the item entering the filter
    logic step;    // item leaves the filter stage this cycle
    logic ready;   // that item carries data_ready
    logic primed;  // history already loaded
  } filt_ctrl_t;

endpackage

// ===== hw/rtl/iaal_cal_lane.sv =====
module iaal_cal_lane (
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] src_x,
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] src_y,
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] src_z,
  input  logic [2:0]                           field,
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] offset,
  output logic signed [iaal_pkg::SAMPLE_W-1:0] cal
);

  logic signed [iaal_pkg::SAMPLE_W:0]   pick;
  logic signed [iaal_pkg::SAMPLE_W:0]   val;
  logic signed [iaal_pkg::SAMPLE_W+1:0] sum;

  always_comb begin
    unique case (field[1:0])
      2'd0:               pick = (iaal_pkg::SAMPLE_W+1)'(src_x);
      2'd1:               pick = (iaal_pkg::SAMPLE_W+1)'(src_y);
      2'd2:               pick = (iaal_pkg::SAMPLE_W+1)'(src_z);
      iaal_pkg::SRC_ZERO: pick = '0;
      default:            pick = '0;
    endcase
    // 17 bits so that negating -32768 stays exact
    val = field[2] ? -pick : pick;
    sum = (iaal_pkg::SAMPLE_W+2)'(val) + (iaal_pkg::SAMPLE_W+2)'(offset);
    if (sum[iaal_pkg::SAMPLE_W+1:iaal_pkg::SAMPLE_W-1] == 3'b000 ||
        sum[iaal_pkg::SAMPLE_W+1:iaal_pkg::SAMPLE_W-1] == 3'b111) begin
      cal = sum[iaal_pkg::SAMPLE_W-1:0];
    end else if (sum[iaal_pkg::SAMPLE_W+1]) begin
      cal = {1'b1, {(iaal_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      cal = {1'b0, {(iaal_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

// ===== hw/rtl/iaal_filt_lane.sv =====
module iaal_filt_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  iaal_pkg::filt_ctrl_t                 ctrl,
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] x_in,
  output logic signed [iaal_pkg::FILT_W-1:0]   y_next
);

  localparam int unsigned PB_W = iaal_pkg::COEF_B_W + iaal_pkg::SAMPLE_W;
  localparam int unsigned ACC_W = iaal_pkg::ACC_W;

  logic signed [iaal_pkg::FILT_W-1:0]   hist_newer;
  logic signed [iaal_pkg::FILT_W-1:0]   hist_older;
  logic signed [2*iaal_pkg::FILT_W-1:0] p1;
  logic signed [2*iaal_pkg::FILT_W-1:0] p2;
  logic signed [PB_W-1:0]               p3;
  logic signed [iaal_pkg::SAMPLE_W-1:0] xm;

  logic signed [iaal_pkg::FILT_W-1:0]         x_q16;
  logic signed [ACC_W-1:0]                    acc;
  logic signed [ACC_W-iaal_pkg::Q_SHIFT-1:0]  r;
  logic signed [iaal_pkg::FILT_W-1:0]         y_sat;

  // products for the item entering the stage
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      p1 <= (2*iaal_pkg::FILT_W)'(iaal_pkg::COEF_A1) * (2*iaal_pkg::FILT_W)'(hist_newer);
      p2 <= (2*iaal_pkg::FILT_W)'(iaal_pkg::COEF_A2) * (2*iaal_pkg::FILT_W)'(hist_older);
      p3 <= PB_W'(iaal_pkg::COEF_B) * PB_W'(x_in);
      xm <= x_in;
    end
  end

  always_comb begin
    x_q16 = $signed({xm, {(iaal_pkg::FILT_W-iaal_pkg::SAMPLE_W){1'b0}}});
    acc = ACC_W'(p1) + ACC_W'(p2)
        + ACC_W'($signed({p3, {(iaal_pkg::FILT_W-iaal_pkg::SAMPLE_W){1'b0}}}))
        + iaal_pkg::ROUND_HALF;
    r = acc[ACC_W-1:iaal_pkg::Q_SHIFT];   // floor shift
    if (r[ACC_W-iaal_pkg::Q_SHIFT-1:iaal_pkg::FILT_W-1] == '0 ||
        r[ACC_W-iaal_pkg::Q_SHIFT-1:iaal_pkg::FILT_W-1] == '1) begin
      y_sat = r[iaal_pkg::FILT_W-1:0];
    end else if (r[ACC_W-iaal_pkg::Q_SHIFT-1]) begin
      y_sat = {1'b1, {(iaal_pkg::FILT_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(iaal_pkg::FILT_W-1){1'b1}}};
    end
    if (!ctrl.ready) begin
      y_next = hist_newer;
    end else if (!ctrl.primed) begin
      y_next = x_q16;
    end else begin
      y_next = y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_newer <= '0;
      hist_older <= '0;
    end else if (ctrl.step && ctrl.ready) begin
      hist_newer <= y_next;
      hist_older <= ctrl.primed ? hist_newer : x_q16;
    end
  end

endmodule

// ===== hw/rtl/imu_axis_align_lowpass_unit.sv =====
// channel  handshake            payload
// -------  -------------------  ------------------------------------------------
// input    in_valid / in_stall  raw_gyro_x/y/z, raw_accel_x/y/z, data_ready
// output   out_valid/out_stall  gyro_cal_*, accel_cal_*, accel_filt_*, filter_primed
// config   cfg_write            cfg_index, cfg_data (no wait, no read-back)
//
// Three register stages (calibrate, multiply, sum/round); out_valid rises when an
// item enters the output register. An item with data_ready leaves the filter stage
// before the next one enters, since the recursion needs the history it writes;
// others go one per cycle while the output is not stalled.
// Synchronous reset clears history, primed flag, offsets and all valid bits, and loads AXIS_MAP_RESET.
// out_stall holds the output register; the calibrate stage still takes an item while it is empty or can advance.
module imu_axis_align_lowpass_unit (
  input  logic                                 clk,
  input  logic                                 rst,

  input  logic                                 cfg_write,
  input  logic [iaal_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [iaal_pkg::SAMPLE_W-1:0]        cfg_data,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] raw_gyro_x,
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] raw_gyro_y,
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] raw_gyro_z,
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] raw_accel_x,
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] raw_accel_y,
  input  logic signed [iaal_pkg::SAMPLE_W-1:0] raw_accel_z,
  input  logic                                 data_ready,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [iaal_pkg::SAMPLE_W-1:0] gyro_cal_x,
  output logic signed [iaal_pkg::SAMPLE_W-1:0] gyro_cal_y,
  output logic signed [iaal_pkg::SAMPLE_W-1:0] gyro_cal_z,
  output logic signed [iaal_pkg::SAMPLE_W-1:0] accel_cal_x,
  output logic signed [iaal_pkg::SAMPLE_W-1:0] accel_cal_y,
  output logic signed [iaal_pkg::SAMPLE_W-1:0] accel_cal_z,
  output logic signed [iaal_pkg::FILT_W-1:0]   accel_filt_x,
  output logic signed [iaal_pkg::FILT_W-1:0]   accel_filt_y,
  output logic signed [iaal_pkg::FILT_W-1:0]   accel_filt_z,
  output logic                                 filter_primed
);

  localparam int unsigned W = iaal_pkg::SAMPLE_W;

  // config registers
  logic [iaal_pkg::MAP_W-1:0] axis_map;
  logic signed [W-1:0] goff [3];
  logic signed [W-1:0] aoff [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_map <= iaal_pkg::AXIS_MAP_RESET;
      goff     <= '{default: '0};
      aoff     <= '{default: '0};
    end else if (cfg_write) begin
      unique case (cfg_index)
        iaal_pkg::CFG_AXIS_MAP:       axis_map <= cfg_data[iaal_pkg::MAP_W-1:0];
        iaal_pkg::CFG_GYRO_OFFSET_X:  goff[0]  <= cfg_data;
        iaal_pkg::CFG_GYRO_OFFSET_Y:  goff[1]  <= cfg_data;
        iaal_pkg::CFG_GYRO_OFFSET_Z:  goff[2]  <= cfg_data;
        iaal_pkg::CFG_ACCEL_OFFSET_X: aoff[0]  <= cfg_data;
        iaal_pkg::CFG_ACCEL_OFFSET_Y: aoff[1]  <= cfg_data;
        iaal_pkg::CFG_ACCEL_OFFSET_Z: aoff[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // calibrate lanes
  logic signed [W-1:0] gcal [3];
  logic signed [W-1:0] acal [3];

  for (genvar k = 0; k < 3; k++) begin : g_cal
    iaal_cal_lane u_gyro (
      .src_x  (raw_gyro_x),
      .src_y  (raw_gyro_y),
      .src_z  (raw_gyro_z),
      .field  (axis_map[3*k +: 3]),
      .offset (goff[k]),
      .cal    (gcal[k])
    );
    iaal_cal_lane u_accel (
      .src_x  (raw_accel_x),
      .src_y  (raw_accel_y),
      .src_z  (raw_accel_z),
      .field  (axis_map[3*k +: 3]),
      .offset (aoff[k]),
      .cal    (acal[k])
    );
  end

  // pipeline control
  logic s1_valid, s1_ready;
  logic m_valid, m_ready;
  logic primed;
  logic in_accept, out_free, step, s1_adv;

  logic signed [W-1:0] s1_gcal [3];
  logic signed [W-1:0] s1_acal [3];
  logic signed [W-1:0] m_gcal [3];
  logic signed [W-1:0] m_acal [3];

  iaal_pkg::filt_ctrl_t fctrl;
  logic signed [iaal_pkg::FILT_W-1:0] y_next [3];

  always_comb begin
    out_free  = !out_valid || !out_stall;
    step      = m_valid && out_free;
    // a ready item in the filter stage must write history before the next one multiplies
    s1_adv    = s1_valid && (!m_valid || (step && !m_ready));
    in_stall  = s1_valid && !s1_adv;
    in_accept = in_valid && !in_stall;
    fctrl.load   = s1_adv;
    fctrl.step   = step;
    fctrl.ready  = m_ready;
    fctrl.primed = primed;
  end

  for (genvar k = 0; k < 3; k++) begin : g_filt
    iaal_filt_lane u_filt (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (fctrl),
      .x_in   (s1_acal[k]),
      .y_next (y_next[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
      primed    <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_valid <= 1'b1;
      end else if (step) begin
        m_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (step && m_ready) begin
        primed <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_gcal  <= gcal;
      s1_acal  <= acal;
      s1_ready <= data_ready;
    end
    if (s1_adv) begin
      m_gcal  <= s1_gcal;
      m_acal  <= s1_acal;
      m_ready <= s1_ready;
    end
    // merge lane results into the output item
    if (step) begin
      gyro_cal_x    <= m_gcal[0];
      gyro_cal_y    <= m_gcal[1];
      gyro_cal_z    <= m_gcal[2];
      accel_cal_x   <= m_acal[0];
      accel_cal_y   <= m_acal[1];
      accel_cal_z   <= m_acal[2];
      accel_filt_x  <= y_next[0];
      accel_filt_y  <= y_next[1];
      accel_filt_z  <= y_next[2];
      filter_primed <= primed || m_ready;
    end
  end

endmodule
